>>> sv/bfsa_pkg.sv
// Shared constants and helpers for the best-fit suballocator.
`timescale 1ns / 1ps
package bfsa_pkg;

    localparam int unsigned DEF_MAX_FRAGMENTS = 32;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned IN_DW  = 64;
    localparam int unsigned OUT_DW = 224;
    localparam int unsigned ADDR_W = 3;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPACT = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_COMPACTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_OOM       = 3'd2;
    localparam logic [STAT_W-1:0] ST_MOVE      = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_ALIGN    = 1'b1;

    // (loc, size) ordering used by the compaction walk
    function automatic logic key_less(input logic [31:0] a_loc, input logic [31:0] a_sz,
                                      input logic [31:0] b_loc, input logic [31:0] b_sz);
        key_less = (a_loc < b_loc) || ((a_loc == b_loc) && (a_sz < b_sz));
    endfunction

endpackage

>>> sv/best_fit_suballocator_with_compaction.sv
// Best-fit suballocator top level: fragment table, scan sequencer and result register.
`timescale 1ns / 1ps
// Sub-allocates one linear buffer. Each request is one beat on s_axis and gives one or more
// result beats on m_axis, the final one with tlast. The block takes one request at a time:
// a single compare unit walks the fragment table one entry per cycle. Allocate scans the
// whole table, then splits or removes the best fit or bumps the top pointer; free scans for
// the first empty slot, and a zero or oversize free skips the scan. Compaction on request
// sorts by repeated minimum search; an allocate that overflows compacts after its first
// scan. A sink that stalls on move beats or on the final beat holds the block back.
module best_fit_suballocator_with_compaction
#(
    parameter int unsigned MAX_FRAGMENTS = bfsa_pkg::DEF_MAX_FRAGMENTS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // req_size[31:0], free_offset[63:32]
    input  logic [bfsa_pkg::IN_DW-1:0]    s_axis_tdata,
    // opcode[1:0]
    input  logic [bfsa_pkg::OP_W-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // location, move_src, move_dst, move_len, gap_location, gap_shift, used_bytes
    output logic [bfsa_pkg::OUT_DW-1:0]   m_axis_tdata,
    // status[2:0]
    output logic [bfsa_pkg::STAT_W-1:0]   m_axis_tuser,
    output logic                          m_axis_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfsa_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bfsa_pkg::*;

    localparam int unsigned IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_FRAGMENTS + 1);
    localparam int unsigned RED_W = 32 + CNT_W;

    typedef enum logic [3:0] {
        IDLE, A_SCAN, A_HIT, A_TOP, C_SCAN, C_STEP, C_LAST, C_END, C_FIN, F_SCAN, DONE
    } state_t;

    state_t                   state_reg;
    logic [OP_W-1:0]          op_reg;
    logic [32:0]              size_reg;
    logic [31:0]              off_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic                     found_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [31:0]              best_loc_reg;
    logic [31:0]              best_sz_reg;
    logic [31:0]              prev_loc_reg;
    logic [31:0]              prev_sz_reg;
    logic                     have_prev_reg;
    logic [MAX_FRAGMENTS-1:0] taken_reg;
    logic [RED_W-1:0]         red_reg;
    logic [MAX_FRAGMENTS-1:0] valid_reg;
    logic [31:0]              loc_mem [MAX_FRAGMENTS];
    logic [31:0]              sz_mem  [MAX_FRAGMENTS];
    logic [32:0]              top_reg;
    logic [32:0]              total_reg;
    logic [31:0]              cap_reg;
    logic [4:0]               align_reg;
    logic [STAT_W-1:0]        res_status_reg;
    logic [31:0]              res_loc_reg;
    logic                     m_valid_reg;
    logic [OUT_DW-1:0]        m_data_reg;
    logic [STAT_W-1:0]        m_user_reg;
    logic                     m_last_reg;

    logic [32:0]      align_mask;
    logic [32:0]      size_rnd;
    logic [IDX_W-1:0] rd_idx;
    logic [31:0]      rd_loc;
    logic [31:0]      rd_sz;
    logic             rd_valid;
    logic             rd_taken;
    logic             scan_last;
    logic             fit_hit;
    logic             min_hit;
    logic [33:0]      bump;
    logic             over;
    logic [33:0]      total_sum;
    logic [32:0]      total_add;
    logic [32:0]      total_sub;
    logic [32:0]      next_pos;
    logic [32:0]      mv_end;
    logic [32:0]      mv_copy;
    logic [31:0]      mv_dst;
    logic [RED_W-1:0] red_add;
    logic [32:0]      top_low;
    logic             out_free;
    logic             m_load;
    logic             accept;
    logic             cfg_wr;

    assign align_mask = (33'd1 << align_reg) - 33'd1;
    assign size_rnd   = ({1'b0, s_axis_tdata[31:0]} + align_mask) & ~align_mask;

    assign rd_idx    = idx_reg[IDX_W-1:0];
    assign rd_loc    = loc_mem[rd_idx];
    assign rd_sz     = sz_mem[rd_idx];
    assign rd_valid  = valid_reg[rd_idx];
    assign rd_taken  = taken_reg[rd_idx];
    assign scan_last = (idx_reg == CNT_W'(MAX_FRAGMENTS - 1));

    assign fit_hit = rd_valid && ({1'b0, rd_sz} >= size_reg)
                     && (!found_reg || (rd_sz < best_sz_reg)
                         || ((rd_sz == best_sz_reg) && (rd_loc < best_loc_reg)));
    assign min_hit = rd_valid && !rd_taken
                     && (!found_reg || key_less(rd_loc, rd_sz, best_loc_reg, best_sz_reg));

    assign bump      = {1'b0, top_reg} + {1'b0, size_reg};
    assign over      = (bump > {2'b0, cap_reg});
    assign total_sum = {1'b0, total_reg} + {1'b0, size_reg};
    assign total_add = total_sum[33] ? {33{1'b1}} : total_sum[32:0];
    assign total_sub = (total_reg >= size_reg) ? (total_reg - size_reg) : 33'd0;

    assign next_pos = (state_reg == C_LAST) ? top_reg : {1'b0, best_loc_reg};
    assign mv_end   = {1'b0, prev_loc_reg} + {1'b0, prev_sz_reg};
    assign mv_copy  = (next_pos > mv_end) ? (next_pos - mv_end) : 33'd0;
    assign mv_dst   = prev_loc_reg - red_reg[31:0];
    assign red_add  = red_reg + RED_W'(prev_sz_reg);
    assign top_low  = (RED_W'(top_reg) >= red_reg) ? (top_reg - red_reg[32:0]) : 33'd0;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign m_load   = out_free && ((state_reg == DONE)
                      || (((state_reg == C_STEP) || (state_reg == C_LAST))
                          && have_prev_reg && (mv_copy != 33'd0)));
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign s_axis_tready = (state_reg == IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_ALIGN) ? {27'd0, align_reg} : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            taken_reg     <= '0;
            red_reg       <= '0;
            valid_reg     <= '0;
            top_reg       <= '0;
            total_reg     <= '0;
            cap_reg       <= '0;
            align_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == REG_ALIGN)
                    align_reg <= pwdata[4:0];
                else
                    cap_reg <= pwdata;
            end
            if (m_valid_reg && m_axis_tready && !m_load)
                m_valid_reg <= 1'b0;

            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        op_reg        <= s_axis_tuser;
                        size_reg      <= size_rnd;
                        off_reg       <= s_axis_tdata[63:32];
                        idx_reg       <= '0;
                        found_reg     <= 1'b0;
                        taken_reg     <= '0;
                        red_reg       <= '0;
                        have_prev_reg <= 1'b0;
                        res_status_reg <= ST_OK;
                        res_loc_reg   <= '0;
                        case (s_axis_tuser)
                            OP_ALLOC:   state_reg <= A_SCAN;
                            OP_FREE:
                            begin
                                if ((size_rnd == 33'd0) || size_rnd[32])
                                    state_reg <= DONE;
                                else
                                    state_reg <= F_SCAN;
                            end
                            OP_COMPACT: state_reg <= C_SCAN;
                            default:    state_reg <= DONE;
                        endcase
                    end
                end
                A_SCAN:
                begin
                    if (fit_hit)
                    begin
                        found_reg    <= 1'b1;
                        best_idx_reg <= rd_idx;
                        best_loc_reg <= rd_loc;
                        best_sz_reg  <= rd_sz;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (scan_last)
                        state_reg <= (found_reg || fit_hit) ? A_HIT : A_TOP;
                end
                A_HIT:
                begin
                    if (best_sz_reg != size_reg[31:0])
                    begin
                        loc_mem[best_idx_reg] <= best_loc_reg + size_reg[31:0];
                        sz_mem[best_idx_reg]  <= best_sz_reg - size_reg[31:0];
                    end
                    else
                        valid_reg[best_idx_reg] <= 1'b0;
                    total_reg   <= total_add;
                    res_loc_reg <= best_loc_reg;
                    state_reg   <= DONE;
                end
                A_TOP:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    if (over)
                        state_reg <= C_SCAN;
                    else
                    begin
                        res_loc_reg <= top_reg[31:0];
                        top_reg     <= bump[32:0];
                        total_reg   <= total_add;
                        state_reg   <= DONE;
                    end
                end
                C_SCAN:
                begin
                    if (min_hit)
                    begin
                        found_reg    <= 1'b1;
                        best_idx_reg <= rd_idx;
                        best_loc_reg <= rd_loc;
                        best_sz_reg  <= rd_sz;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (scan_last)
                        state_reg <= (found_reg || min_hit) ? C_STEP : C_LAST;
                end
                C_STEP, C_LAST:
                begin
                    if (!(have_prev_reg && (mv_copy != 33'd0) && !out_free))
                    begin
                        if (have_prev_reg)
                        begin
                            red_reg <= red_add;
                            if (mv_copy != 33'd0)
                            begin
                                m_valid_reg <= 1'b1;
                                m_user_reg  <= ST_MOVE;
                                m_last_reg  <= 1'b0;
                                m_data_reg  <= {total_reg[31:0], prev_sz_reg, prev_loc_reg,
                                                mv_copy[31:0], mv_dst, mv_end[31:0], 32'd0};
                            end
                        end
                        if (state_reg == C_STEP)
                        begin
                            taken_reg[best_idx_reg] <= 1'b1;
                            prev_loc_reg  <= best_loc_reg;
                            prev_sz_reg   <= best_sz_reg;
                            have_prev_reg <= 1'b1;
                            found_reg     <= 1'b0;
                            idx_reg       <= '0;
                            state_reg     <= C_SCAN;
                        end
                        else
                            state_reg <= C_END;
                    end
                end
                C_END:
                begin
                    top_reg   <= top_low;
                    valid_reg <= '0;
                    state_reg <= C_FIN;
                end
                C_FIN:
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        if (over)
                        begin
                            res_status_reg <= ST_OOM;
                            res_loc_reg    <= {32{1'b1}};
                        end
                        else
                        begin
                            res_status_reg <= ST_COMPACTED;
                            res_loc_reg    <= top_reg[31:0];
                            top_reg        <= bump[32:0];
                            total_reg      <= total_add;
                        end
                    end
                    state_reg <= DONE;
                end
                F_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (!rd_valid)
                    begin
                        valid_reg[rd_idx] <= 1'b1;
                        loc_mem[rd_idx]   <= off_reg;
                        sz_mem[rd_idx]    <= size_reg[31:0];
                        total_reg         <= total_sub;
                        state_reg         <= DONE;
                    end
                    else if (scan_last)
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= DONE;
                    end
                end
                DONE:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= res_status_reg;
                        m_last_reg  <= 1'b1;
                        m_data_reg  <= {total_reg[31:0], 160'd0, res_loc_reg};
                        state_reg   <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

>>> sv/bfsa_checker.sv
// Port-level checks for the best-fit suballocator, bound to the top level.
`timescale 1ns / 1ps
module bfsa_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [bfsa_pkg::OUT_DW-1:0]   m_axis_tdata,
    input logic [bfsa_pkg::STAT_W-1:0]   m_axis_tuser,
    input logic                          m_axis_tlast
);
    import bfsa_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a request is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

    a_move_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_MOVE)) |-> !m_axis_tlast)
        else $error("move beat marked last");

    a_oom_location: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_OOM)) |-> (m_axis_tdata[31:0] == 32'hFFFF_FFFF))
        else $error("out of memory without all-ones location");

endmodule

bind best_fit_suballocator_with_compaction bfsa_checker u_bfsa_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/tb_best_fit_suballocator_with_compaction.sv
// Testbench for the best-fit suballocator: directed and random requests checked against a behavioral predictor.
`timescale 1ns / 1ps
module tb_best_fit_suballocator_with_compaction;
    import bfsa_pkg::*;

    localparam int NFRAG = 32;
    localparam longint M32 = 64'hFFFF_FFFF;
    localparam longint M33 = 64'h1_FFFF_FFFF;
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] location;
        logic [31:0] move_src;
        logic [31:0] move_dst;
        logic [31:0] move_len;
        logic [31:0] gap_location;
        logic [31:0] gap_shift;
        logic [31:0] used_bytes;
        logic        last;
    } alloc_result_t;

    class alloc_scoreboard;
        alloc_result_t pending[$];
        int            mismatches;
        longint        capacity;
        int            align;
        logic [31:0]   frag_loc[NFRAG];
        logic [31:0]   frag_sz[NFRAG];
        bit            frag_ok[NFRAG];
        longint        top;
        longint        used;

        function new();
            mismatches = 0;
            capacity = 0;
            align = 0;
            top = 0;
            used = 0;
            foreach (frag_ok[i]) frag_ok[i] = 0;
        endfunction

        function void push(logic [2:0] st, longint loc, longint src, longint dst,
                           longint len, longint gl, longint gs, bit lst);
            alloc_result_t r;
            r.status = st;
            r.location = loc[31:0];
            r.move_src = src[31:0];
            r.move_dst = dst[31:0];
            r.move_len = len[31:0];
            r.gap_location = gl[31:0];
            r.gap_shift = gs[31:0];
            r.used_bytes = used[31:0];
            r.last = lst;
            pending = {pending, r};
        endfunction

        function void compact_table();
            longint l[$];
            longint s[$];
            longint red;
            longint nxt;
            longint e;
            longint tl;
            longint ts;
            int j;
            red = 0;
            for (int i = 0; i < NFRAG; i++)
                if (frag_ok[i])
                begin
                    l = {l, longint'(frag_loc[i])};
                    s = {s, longint'(frag_sz[i])};
                end
            for (int i = 1; i < l.size(); i++)
            begin
                j = i;
                while (j > 0 && (l[j-1] > l[j] || (l[j-1] == l[j] && s[j-1] > s[j])))
                begin
                    tl = l[j]; l[j] = l[j-1]; l[j-1] = tl;
                    ts = s[j]; s[j] = s[j-1]; s[j-1] = ts;
                    j--;
                end
            end
            for (int i = 0; i < l.size(); i++)
            begin
                nxt = (i + 1 < l.size()) ? l[i+1] : top;
                e = l[i] + s[i];
                if (nxt > e)
                    push(ST_MOVE, 0, e, (l[i] - red) & M32, nxt - e, l[i], s[i], 0);
                red += s[i];
            end
            top = (top >= red) ? top - red : 0;
            foreach (frag_ok[i]) frag_ok[i] = 0;
        endfunction

        function void note_request(logic [1:0] op, logic [31:0] rsize, logic [31:0] off);
            longint a;
            longint sz;
            longint where;
            longint rem;
            int best;
            logic [2:0] st;
            a = 64'd1 << align;
            sz = (longint'(rsize) + a - 1) & ~(a - 1);
            if (op == OP_ALLOC)
            begin
                best = -1;
                for (int i = 0; i < NFRAG; i++)
                begin
                    if (!frag_ok[i] || longint'(frag_sz[i]) < sz) continue;
                    if (best < 0 || frag_sz[i] < frag_sz[best] ||
                        (frag_sz[i] == frag_sz[best] && frag_loc[i] < frag_loc[best]))
                        best = i;
                end
                if (best >= 0)
                begin
                    where = frag_loc[best];
                    rem = longint'(frag_sz[best]) - sz;
                    if (rem > 0)
                    begin
                        frag_loc[best] = 32'((where + sz) & M32);
                        frag_sz[best] = rem[31:0];
                    end
                    else
                        frag_ok[best] = 0;
                    used += sz;
                    if (used > M33) used = M33;
                    push(ST_OK, where, 0, 0, 0, 0, 0, 1);
                    return;
                end
                st = ST_OK;
                if (top + sz > capacity)
                begin
                    compact_table();
                    if (top + sz > capacity)
                    begin
                        push(ST_OOM, M32, 0, 0, 0, 0, 0, 1);
                        return;
                    end
                    st = ST_COMPACTED;
                end
                where = top;
                top = (top + sz) & M33;
                used += sz;
                if (used > M33) used = M33;
                push(st, where, 0, 0, 0, 0, 0, 1);
            end
            else if (op == OP_FREE)
            begin
                if (sz == 0 || sz > M32)
                begin
                    push(ST_OK, 0, 0, 0, 0, 0, 0, 1);
                    return;
                end
                best = -1;
                for (int i = 0; i < NFRAG; i++)
                    if (!frag_ok[i] && best < 0) best = i;
                if (best < 0)
                begin
                    push(ST_FULL, 0, 0, 0, 0, 0, 0, 1);
                    return;
                end
                frag_ok[best] = 1;
                frag_loc[best] = off;
                frag_sz[best] = sz[31:0];
                used = (used >= sz) ? used - sz : 0;
                push(ST_OK, 0, 0, 0, 0, 0, 0, 1);
            end
            else
            begin
                if (op == OP_COMPACT) compact_table();
                push(ST_OK, 0, 0, 0, 0, 0, 0, 1);
            end
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_DW-1:0] s_axis_tdata = '0;
    logic [OP_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic [STAT_W-1:0] m_axis_tuser;
    logic m_axis_tlast;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    alloc_scoreboard sb = new();
    longint cycles = 0;
    bit stim_done = 0;

    always #5 clk = ~clk;

    best_fit_suballocator_with_compaction dut (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge clk)
    begin
        alloc_result_t r;
        cycles++;
        if (cycles > 2000000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            r.status = m_axis_tuser;
            r.location = m_axis_tdata[31:0];
            r.move_src = m_axis_tdata[63:32];
            r.move_dst = m_axis_tdata[95:64];
            r.move_len = m_axis_tdata[127:96];
            r.gap_location = m_axis_tdata[159:128];
            r.gap_shift = m_axis_tdata[191:160];
            r.used_bytes = m_axis_tdata[223:192];
            r.last = m_axis_tlast;
            sb.check_result(r);
        end
    end

    initial
    begin
        int g;
        @(posedge clk);
        forever
        begin
            g = stim_done ? 0 : gap_len();
            if ($urandom_range(0, 3) == 0) g = 0;
            m_axis_tready <= (g == 0);
            repeat (g > 0 ? g : 1) @(posedge clk);
            if (g > 0)
            begin
                m_axis_tready <= 1;
                @(posedge clk);
            end
        end
    end

    task automatic apb_write(input logic idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == REG_CAPACITY) sb.capacity = longint'(val);
        else sb.align = int'(val[4:0]);
        @(posedge clk);
    endtask

    task automatic send_request(input logic [1:0] op, input logic [31:0] rsize,
                                input logic [31:0] off);
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {off, rsize};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_request(op, rsize, off);
        s_axis_tvalid <= 0;
        @(posedge clk);
        repeat (gap_len()) @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    task automatic random_phase(input int n, input int span);
        logic [31:0] sz;
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            sz = $urandom_range(0, span);
            if (k < 50) send_request(OP_ALLOC, sz, 0);
            else if (k < 85) send_request(OP_FREE, sz, $urandom_range(0, 4 * span));
            else if (k < 92) send_request(OP_COMPACT, $urandom, $urandom);
            else if (k < 96) send_request(OP_NOP, $urandom, $urandom);
            else send_request(k[0] ? OP_ALLOC : OP_FREE, $urandom, $urandom);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        apb_write(REG_CAPACITY, 32'd4096);
        apb_write(REG_ALIGN, 32'd4);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 100, 0);
        send_request(OP_ALLOC, 1000, 0);
        send_request(OP_ALLOC, 500, 0);
        send_request(OP_FREE, 100, 112);
        send_request(OP_FREE, 0, 50);
        send_request(OP_FREE, 32'hFFFF_FFFF, 0);
        send_request(OP_ALLOC, 40, 0);
        send_request(OP_ALLOC, 3000, 0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 0);
        send_request(OP_FREE, 64, 32'hFFFF_FFF0);
        send_request(OP_ALLOC, 16, 0);
        send_request(OP_COMPACT, 0, 0);
        send_request(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 33; i++) send_request(OP_FREE, 16, 32 * i);
        drain();

        apb_write(REG_ALIGN, 32'd0);
        apb_write(REG_CAPACITY, 32'hFFFF_FFFF);
        random_phase(25, 200);
        drain();

        apb_write(REG_CAPACITY, 32'd0);
        apb_write(REG_ALIGN, 32'd16);
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_FREE, 32'h8000_0000, 32'h1234_5678);
        random_phase(10, 70000);
        drain();

        apb_write(REG_CAPACITY, 32'd1500);
        apb_write(REG_ALIGN, 32'd3);
        random_phase(25, 300);
        stim_done = 1;
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
